[rtl/overlap_susceptibility_accumulator_macros.svh]
// assertion macros for the overlap susceptibility accumulator rtl
// no dependencies; included by osa_datapath.sv
`ifndef OVERLAP_SUSCEPTIBILITY_ACCUMULATOR_MACROS_SVH
`define OVERLAP_SUSCEPTIBILITY_ACCUMULATOR_MACROS_SVH
`ifndef NO_ASSERTIONS
// same-cycle implication
`define OSA_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("osa assertion failed");
// next-cycle implication
`define OSA_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("osa assertion failed");
`else
`define OSA_ASSERT_NOW(label, clk, rstn, ante, cons)
`define OSA_ASSERT_NEXT(label, clk, rstn, ante, cons)
`endif
`endif

[rtl/osa_pkg.sv]
// shared types and constants of the overlap susceptibility accumulator
// no dependencies; used by every rtl module of the block
`timescale 1ns / 1ps
`default_nettype none

package osa_pkg;

    localparam int COORD_W   = 32;
    localparam int AXES      = 3;
    localparam int CFG_W     = 64;
    localparam int CFG_IDX_W = 3;
    localparam int OVL_W     = 64;
    localparam int DIMS_W    = 2;
    localparam int INV_W     = 32;
    localparam int BOX_W     = 48;

    localparam int SUM_W     = 29;
    localparam int SQSUM_W   = 45;
    localparam int MEAN_W    = 32;
    localparam int CHI_W     = 64;

    // shared multiplier: 3 x 2 limbs of 32 bits
    localparam int LIMB_W    = 32;
    localparam int MUL_A_W   = 96;
    localparam int MUL_B_W   = 64;
    localparam int MUL_P_W   = 160;

    // widths of the lag-end intermediates
    localparam int P_W       = 61;
    localparam int Q_W       = 77;
    localparam int M2_W      = 90;
    localparam int R_W       = 112;

    localparam int DEF_MAX_ATOMS   = 65536;
    localparam int DEF_MAX_WINDOWS = 4096;

    localparam logic [CFG_IDX_W-1:0] REG_OVERLAP_SQ    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DIMS_IN_USE   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_INV_PAIR      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_INV_ATOM      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_BOX_VOLUME    = 3'd4;

    localparam logic [OVL_W-1:0]  RST_OVERLAP_SQ = 64'h0000_0001_0000_0000;
    localparam logic [DIMS_W-1:0] RST_DIMS       = 2'd3;
    localparam logic [INV_W-1:0]  RST_INV        = 32'hFFFF_FFFF;
    localparam logic [BOX_W-1:0]  RST_BOX        = 48'h0000_0001_0000;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SQUARE,
        ST_TALLY,
        ST_CLOSE_SQ,
        ST_CLOSE_ADD,
        ST_MUL_GO,
        ST_MUL_WAIT,
        ST_DIFF,
        ST_CHI_FIN,
        ST_OUT
    } state_t;

    typedef enum logic [2:0] {
        MUL_P,
        MUL_Q,
        MUL_Q2,
        MUL_M2,
        MUL_CHI
    } mul_op_t;

    typedef struct packed {
        logic    load_item;
        logic    square;
        logic    tally;
        logic    close_sq;
        logic    close_add;
        logic    mul_start;
        logic    cap_en;
        mul_op_t mul_op;
        logic    diff;
        logic    chi_fin;
        logic    load_out;
    } cmd_t;

    typedef struct packed {
        logic mul_busy;
        logic last_atom;
        logic last_window;
    } status_t;

endpackage

`default_nettype wire

[rtl/osa_mul.sv]
// sequential 96 x 64 bit multiplier built on one 32 x 32 multiplier
// depends on osa_pkg; used by osa_datapath
`timescale 1ns / 1ps
`default_nettype none

module osa_mul (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic [osa_pkg::MUL_A_W-1:0]   a,
    input  logic [osa_pkg::MUL_B_W-1:0]   b,
    output logic                          busy,
    output logic [osa_pkg::MUL_P_W-1:0]   prod
);

    localparam int LW        = osa_pkg::LIMB_W;
    localparam int A_LIMBS   = osa_pkg::MUL_A_W / osa_pkg::LIMB_W;
    localparam int B_LIMBS   = osa_pkg::MUL_B_W / osa_pkg::LIMB_W;
    localparam logic [2:0] LAST_STEP = 3'(A_LIMBS * B_LIMBS - 1);

    logic [osa_pkg::MUL_A_W-1:0] a_reg;
    logic [osa_pkg::MUL_B_W-1:0] b_reg;
    logic [2:0]                  step_reg;
    logic                        run_reg;
    logic [2*LW-1:0]             pp_reg;
    logic [1:0]                  pp_sh_reg;
    logic                        pp_vld_reg;
    logic [osa_pkg::MUL_P_W-1:0] acc_reg;

    logic [1:0]                  a_idx;
    logic                        b_idx;
    logic [LW-1:0]               a_limb;
    logic [LW-1:0]               b_limb;
    logic [2*LW-1:0]             pp_next;
    logic [osa_pkg::MUL_P_W-1:0] pp_wide;
    logic [osa_pkg::MUL_P_W-1:0] acc_next;

    // step walks b limbs fastest
    assign a_idx   = step_reg[2:1];
    assign b_idx   = step_reg[0];
    assign a_limb  = a_reg[LW*a_idx +: LW];
    assign b_limb  = b_reg[LW*b_idx +: LW];
    assign pp_next = a_limb * b_limb;

    always_comb begin
        case (pp_sh_reg)
            2'd0:    pp_wide = {96'd0, pp_reg};
            2'd1:    pp_wide = {64'd0, pp_reg, 32'd0};
            2'd2:    pp_wide = {32'd0, pp_reg, 64'd0};
            2'd3:    pp_wide = {pp_reg, 96'd0};
            default: pp_wide = '0;
        endcase
        acc_next = acc_reg + pp_wide;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg    <= 1'b0;
            pp_vld_reg <= 1'b0;
            step_reg   <= '0;
        end else if (start) begin
            run_reg    <= 1'b1;
            pp_vld_reg <= 1'b0;
            step_reg   <= '0;
        end else begin
            if (run_reg) begin
                step_reg <= step_reg + 3'd1;
                if (step_reg == LAST_STEP) begin
                    run_reg <= 1'b0;
                end
            end
            pp_vld_reg <= run_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            a_reg   <= a;
            b_reg   <= b;
            acc_reg <= '0;
        end else begin
            if (run_reg) begin
                pp_reg    <= pp_next;
                pp_sh_reg <= a_idx + {1'b0, b_idx};
            end
            if (pp_vld_reg) begin
                acc_reg <= acc_next;
            end
        end
    end

    assign busy = run_reg | pp_vld_reg;
    assign prod = acc_reg;

endmodule

`default_nettype wire

[rtl/osa_datapath.sv]
// datapath: config registers, overlap test, window tallies, lag-end math
// depends on osa_pkg, osa_mul and the assertion macro header
`timescale 1ns / 1ps
`default_nettype none
`include "overlap_susceptibility_accumulator_macros.svh"

module osa_datapath #(
    parameter int MAX_ATOMS   = osa_pkg::DEF_MAX_ATOMS,
    parameter int MAX_WINDOWS = osa_pkg::DEF_MAX_WINDOWS
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic [osa_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [osa_pkg::CFG_W-1:0]           cfg_wr_data,
    input  logic signed [osa_pkg::COORD_W-1:0]  now_x,
    input  logic signed [osa_pkg::COORD_W-1:0]  now_y,
    input  logic signed [osa_pkg::COORD_W-1:0]  now_z,
    input  logic signed [osa_pkg::COORD_W-1:0]  start_x,
    input  logic signed [osa_pkg::COORD_W-1:0]  start_y,
    input  logic signed [osa_pkg::COORD_W-1:0]  start_z,
    input  logic                                last_atom,
    input  logic                                last_window,
    input  osa_pkg::cmd_t                       cmd,
    output osa_pkg::status_t                    status,
    output logic [osa_pkg::SUM_W-1:0]           overlap_sum,
    output logic [osa_pkg::SQSUM_W-1:0]         overlap_square_sum,
    output logic [osa_pkg::MEAN_W-1:0]          mean_overlap,
    output logic signed [osa_pkg::CHI_W-1:0]    chi4_value
);

    localparam int CW     = osa_pkg::COORD_W;
    localparam int CNT_W  = $clog2(MAX_ATOMS + 1);
    localparam int WIN_W  = $clog2(MAX_WINDOWS + 1);
    localparam int CSQ_W  = 2 * CNT_W;
    localparam int SUM_W  = osa_pkg::SUM_W;
    localparam int SQ_W   = osa_pkg::SQSUM_W;
    localparam int P_W    = osa_pkg::P_W;
    localparam int Q_W    = osa_pkg::Q_W;
    localparam int M2_W   = osa_pkg::M2_W;
    localparam int R_W    = osa_pkg::R_W;
    localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};
    localparam logic [SQ_W-1:0]  SQ_MAX  = {SQ_W{1'b1}};
    localparam logic [osa_pkg::CHI_W-1:0] CHI_POS_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [osa_pkg::CHI_W-1:0] CHI_NEG_MIN = 64'h8000_0000_0000_0000;

    function automatic logic [CW-1:0] abs_diff(input logic signed [CW-1:0] x,
                                               input logic signed [CW-1:0] y);
        logic [CW:0] d;
        logic [CW:0] n;
        d = {x[CW-1], x} - {y[CW-1], y};
        n = ~d + 1'b1;
        return d[CW] ? n[CW-1:0] : d[CW-1:0];
    endfunction

    // configuration
    logic [osa_pkg::OVL_W-1:0]  ovl_sq_reg;
    logic [osa_pkg::DIMS_W-1:0] dims_reg;
    logic [osa_pkg::INV_W-1:0]  inv_pair_reg;
    logic [osa_pkg::INV_W-1:0]  inv_atom_reg;
    logic [osa_pkg::BOX_W-1:0]  box_reg;

    // per-atom path
    logic signed [CW-1:0] now_w   [osa_pkg::AXES];
    logic signed [CW-1:0] start_w [osa_pkg::AXES];
    logic [osa_pkg::AXES-1:0] axis_on;
    logic [CW-1:0]   mag_reg [osa_pkg::AXES];
    logic [2*CW-1:0] sq_reg  [osa_pkg::AXES];
    logic            last_atom_reg;
    logic            last_window_reg;
    logic [2*CW:0]   s1;
    logic [2*CW+1:0] s2;
    logic            hit;

    // window tallies
    logic [CNT_W-1:0] open_count_reg;
    logic [WIN_W-1:0] window_count_reg;
    logic [SUM_W-1:0] running_sum_reg;
    logic [SQ_W-1:0]  running_sq_reg;
    logic [CSQ_W-1:0] cnt_sq_reg;
    logic [SUM_W:0]   sum_ext;
    logic [SQ_W:0]    sq_ext;

    // lag-end math
    logic [osa_pkg::MUL_A_W-1:0] mul_a;
    logic [osa_pkg::MUL_B_W-1:0] mul_b;
    logic [osa_pkg::MUL_P_W-1:0] mul_prod;
    logic                        mul_busy;
    logic [P_W-1:0]   p_reg;
    logic [osa_pkg::MEAN_W-1:0] mean_reg;
    logic [Q_W-1:0]   q_reg;
    logic [Q_W-1:0]   q2_reg;
    logic [M2_W-1:0]  m2_reg;
    logic [M2_W-1:0]  dmag_reg;
    logic             neg_reg;
    logic [R_W-1:0]   r_reg;
    logic [osa_pkg::CHI_W-1:0] chi_reg;
    logic [P_W:0]     p_inc;
    logic [osa_pkg::MEAN_W-1:0] mean_next;
    logic [109:0]     q2_sum;
    logic [122:0]     m2_sum;
    logic [128:0]     r_sum;
    logic [M2_W:0]    d_ab;
    logic [M2_W:0]    d_ba;
    logic             big;
    logic             pos_sat;
    logic             neg_sat;
    logic [osa_pkg::CHI_W-1:0] chi_next;

    // result word
    logic [SUM_W-1:0] out_sum_reg;
    logic [SQ_W-1:0]  out_sq_reg;
    logic [osa_pkg::MEAN_W-1:0] out_mean_reg;
    logic [osa_pkg::CHI_W-1:0]  out_chi_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ovl_sq_reg   <= osa_pkg::RST_OVERLAP_SQ;
            dims_reg     <= osa_pkg::RST_DIMS;
            inv_pair_reg <= osa_pkg::RST_INV;
            inv_atom_reg <= osa_pkg::RST_INV;
            box_reg      <= osa_pkg::RST_BOX;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                osa_pkg::REG_OVERLAP_SQ:  ovl_sq_reg   <= cfg_wr_data;
                osa_pkg::REG_DIMS_IN_USE: dims_reg     <= cfg_wr_data[osa_pkg::DIMS_W-1:0];
                osa_pkg::REG_INV_PAIR:    inv_pair_reg <= cfg_wr_data[osa_pkg::INV_W-1:0];
                osa_pkg::REG_INV_ATOM:    inv_atom_reg <= cfg_wr_data[osa_pkg::INV_W-1:0];
                osa_pkg::REG_BOX_VOLUME:  box_reg      <= cfg_wr_data[osa_pkg::BOX_W-1:0];
                default: ;
            endcase
        end
    end

    assign now_w[0]   = now_x;
    assign now_w[1]   = now_y;
    assign now_w[2]   = now_z;
    assign start_w[0] = start_x;
    assign start_w[1] = start_y;
    assign start_w[2] = start_z;

    always_comb begin
        for (int d = 0; d < osa_pkg::AXES; d++) begin
            axis_on[d] = (dims_reg > 2'(d));
        end
    end

    // unused axes enter as zero so they add nothing to the distance
    always_ff @(posedge aclk) begin
        if (cmd.load_item) begin
            for (int d = 0; d < osa_pkg::AXES; d++) begin
                mag_reg[d] <= axis_on[d] ? abs_diff(now_w[d], start_w[d]) : '0;
            end
            last_atom_reg   <= last_atom;
            last_window_reg <= last_window;
        end
        if (cmd.square) begin
            for (int d = 0; d < osa_pkg::AXES; d++) begin
                sq_reg[d] <= mag_reg[d] * mag_reg[d];
            end
        end
        if (cmd.close_sq) begin
            cnt_sq_reg <= open_count_reg * open_count_reg;
        end
    end

    // a squared distance of 2^64 or more never overlaps
    always_comb begin
        s1  = {1'b0, sq_reg[0]} + {1'b0, sq_reg[1]};
        s2  = {1'b0, s1} + {2'b0, sq_reg[2]};
        hit = (s2[2*CW+1:2*CW] == 2'b00) && (s2[2*CW-1:0] <= ovl_sq_reg);
    end

    always_comb begin
        sum_ext = {1'b0, running_sum_reg} + (SUM_W+1)'(open_count_reg);
        sq_ext  = {1'b0, running_sq_reg} + (SQ_W+1)'(cnt_sq_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            open_count_reg   <= '0;
            window_count_reg <= '0;
            running_sum_reg  <= '0;
            running_sq_reg   <= '0;
        end else begin
            if (cmd.tally && hit && (open_count_reg < CNT_W'(MAX_ATOMS))) begin
                open_count_reg <= open_count_reg + 1'b1;
            end
            if (cmd.close_add) begin
                open_count_reg  <= '0;
                running_sum_reg <= sum_ext[SUM_W] ? SUM_MAX : sum_ext[SUM_W-1:0];
                running_sq_reg  <= sq_ext[SQ_W] ? SQ_MAX : sq_ext[SQ_W-1:0];
                if (window_count_reg < WIN_W'(MAX_WINDOWS)) begin
                    window_count_reg <= window_count_reg + 1'b1;
                end
            end
            if (cmd.load_out) begin
                running_sum_reg  <= '0;
                running_sq_reg   <= '0;
                window_count_reg <= '0;
            end
        end
    end

    always_comb begin
        case (cmd.mul_op)
            osa_pkg::MUL_P: begin
                mul_a = osa_pkg::MUL_A_W'(running_sum_reg);
                mul_b = osa_pkg::MUL_B_W'(inv_pair_reg);
            end
            osa_pkg::MUL_Q: begin
                mul_a = osa_pkg::MUL_A_W'(running_sq_reg);
                mul_b = osa_pkg::MUL_B_W'(inv_pair_reg);
            end
            osa_pkg::MUL_Q2: begin
                mul_a = osa_pkg::MUL_A_W'(q_reg);
                mul_b = osa_pkg::MUL_B_W'(inv_atom_reg);
            end
            osa_pkg::MUL_M2: begin
                mul_a = osa_pkg::MUL_A_W'(p_reg);
                mul_b = osa_pkg::MUL_B_W'(p_reg);
            end
            osa_pkg::MUL_CHI: begin
                mul_a = osa_pkg::MUL_A_W'(dmag_reg[79:0]);
                mul_b = osa_pkg::MUL_B_W'(box_reg);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    osa_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.mul_start),
        .a       (mul_a),
        .b       (mul_b),
        .busy    (mul_busy),
        .prod    (mul_prod)
    );

    // round half up before each fixed-point shift
    always_comb begin
        p_inc     = {1'b0, mul_prod[P_W-1:0]} + 1'b1;
        mean_next = (p_inc[P_W:1] > 61'h0000_0000_8000_0000) ? 32'h8000_0000
                                                             : p_inc[32:1];
        q2_sum    = {1'b0, mul_prod[108:0]} + {78'd0, 32'h8000_0000};
        m2_sum    = {1'b0, mul_prod[121:0]} + {91'd0, 32'h8000_0000};
        r_sum     = {1'b0, mul_prod[127:0]} + {113'd0, 16'h8000};
        d_ab      = {1'b0, 13'd0, q2_reg} - {1'b0, m2_reg};
        d_ba      = {1'b0, m2_reg} - {1'b0, 13'd0, q2_reg};
    end

    // a magnitude of 2^80 or more saturates if the box volume is nonzero
    always_comb begin
        big     = |dmag_reg[M2_W-1:80];
        pos_sat = big || (|r_reg[R_W-1:63]);
        neg_sat = big || (|r_reg[R_W-1:64]) || (r_reg[63:0] > CHI_NEG_MIN);
        if ((box_reg == '0) || (dmag_reg == '0)) begin
            chi_next = '0;
        end else if (!neg_reg) begin
            chi_next = pos_sat ? CHI_POS_MAX : r_reg[63:0];
        end else begin
            chi_next = neg_sat ? CHI_NEG_MIN : (64'd0 - r_reg[63:0]);
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.cap_en) begin
            case (cmd.mul_op)
                osa_pkg::MUL_P: begin
                    p_reg    <= mul_prod[P_W-1:0];
                    mean_reg <= mean_next;
                end
                osa_pkg::MUL_Q:   q_reg  <= mul_prod[Q_W-1:0];
                osa_pkg::MUL_Q2:  q2_reg <= q2_sum[108:32];
                osa_pkg::MUL_M2:  m2_reg <= m2_sum[121:32];
                osa_pkg::MUL_CHI: r_reg  <= r_sum[127:16];
                default: ;
            endcase
        end
        if (cmd.diff) begin
            neg_reg  <= d_ab[M2_W];
            dmag_reg <= d_ab[M2_W] ? d_ba[M2_W-1:0] : d_ab[M2_W-1:0];
        end
        if (cmd.chi_fin) begin
            chi_reg <= chi_next;
        end
        if (cmd.load_out) begin
            out_sum_reg  <= running_sum_reg;
            out_sq_reg   <= running_sq_reg;
            out_mean_reg <= mean_reg;
            out_chi_reg  <= chi_reg;
        end
    end

    assign status.mul_busy    = mul_busy;
    assign status.last_atom   = last_atom_reg;
    assign status.last_window = last_window_reg;

    assign overlap_sum        = out_sum_reg;
    assign overlap_square_sum = out_sq_reg;
    assign mean_overlap       = out_mean_reg;
    assign chi4_value         = out_chi_reg;

    `OSA_ASSERT_NOW(a_count_bound, aclk, aresetn, 1'b1, open_count_reg <= CNT_W'(MAX_ATOMS))
    `OSA_ASSERT_NOW(a_start_when_idle, aclk, aresetn, cmd.mul_start, !mul_busy)
    `OSA_ASSERT_NOW(a_square_dominates, aclk, aresetn, 1'b1, running_sq_reg >= SQ_W'(running_sum_reg))
    `OSA_ASSERT_NEXT(a_clear_after_word, aclk, aresetn, cmd.load_out, (running_sum_reg == '0) && (running_sq_reg == '0))

endmodule

`default_nettype wire

[rtl/osa_ctrl.sv]
// controller: sequences the per-atom steps, window close and lag-end math
// depends on osa_pkg; drives osa_datapath through cmd_t and reads status_t
`timescale 1ns / 1ps
`default_nettype none

module osa_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    output logic              m_valid,
    input  logic              m_ready,
    output osa_pkg::cmd_t     cmd,
    input  osa_pkg::status_t  status
);

    osa_pkg::state_t  state_reg;
    osa_pkg::state_t  state_next;
    osa_pkg::mul_op_t op_reg;
    osa_pkg::mul_op_t op_next;
    logic             m_valid_reg;
    logic             m_valid_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= osa_pkg::ST_IDLE;
            op_reg      <= osa_pkg::MUL_P;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            op_reg      <= op_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_comb begin
        state_next   = state_reg;
        op_next      = op_reg;
        m_valid_next = m_valid_reg;
        s_ready      = 1'b0;
        cmd          = '0;
        cmd.mul_op   = op_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        case (state_reg)
            osa_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load_item = 1'b1;
                    state_next    = osa_pkg::ST_SQUARE;
                end
            end
            osa_pkg::ST_SQUARE: begin
                cmd.square = 1'b1;
                state_next = osa_pkg::ST_TALLY;
            end
            osa_pkg::ST_TALLY: begin
                cmd.tally  = 1'b1;
                state_next = status.last_atom ? osa_pkg::ST_CLOSE_SQ : osa_pkg::ST_IDLE;
            end
            osa_pkg::ST_CLOSE_SQ: begin
                cmd.close_sq = 1'b1;
                state_next   = osa_pkg::ST_CLOSE_ADD;
            end
            osa_pkg::ST_CLOSE_ADD: begin
                cmd.close_add = 1'b1;
                if (status.last_window) begin
                    op_next    = osa_pkg::MUL_P;
                    state_next = osa_pkg::ST_MUL_GO;
                end else begin
                    state_next = osa_pkg::ST_IDLE;
                end
            end
            osa_pkg::ST_MUL_GO: begin
                cmd.mul_start = 1'b1;
                state_next    = osa_pkg::ST_MUL_WAIT;
            end
            osa_pkg::ST_MUL_WAIT: begin
                if (!status.mul_busy) begin
                    cmd.cap_en = 1'b1;
                    case (op_reg)
                        osa_pkg::MUL_P: begin
                            op_next    = osa_pkg::MUL_Q;
                            state_next = osa_pkg::ST_MUL_GO;
                        end
                        osa_pkg::MUL_Q: begin
                            op_next    = osa_pkg::MUL_Q2;
                            state_next = osa_pkg::ST_MUL_GO;
                        end
                        osa_pkg::MUL_Q2: begin
                            op_next    = osa_pkg::MUL_M2;
                            state_next = osa_pkg::ST_MUL_GO;
                        end
                        osa_pkg::MUL_M2:  state_next = osa_pkg::ST_DIFF;
                        osa_pkg::MUL_CHI: state_next = osa_pkg::ST_CHI_FIN;
                        default:          state_next = osa_pkg::ST_IDLE;
                    endcase
                end
            end
            osa_pkg::ST_DIFF: begin
                cmd.diff   = 1'b1;
                op_next    = osa_pkg::MUL_CHI;
                state_next = osa_pkg::ST_MUL_GO;
            end
            osa_pkg::ST_CHI_FIN: begin
                cmd.chi_fin = 1'b1;
                state_next  = osa_pkg::ST_OUT;
            end
            osa_pkg::ST_OUT: begin
                // hold until the output register is free
                if (!m_valid_reg || m_ready) begin
                    cmd.load_out = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = osa_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = osa_pkg::ST_IDLE;
            end
        endcase
    end

    assign m_valid = m_valid_reg;

endmodule

`default_nettype wire

[rtl/overlap_susceptibility_accumulator.sv]
// Overlap susceptibility accumulator, top level.
// Input channel s_*: one atom word per handshake, start and later positions
// (signed Q16.16) with last_atom / last_window marks. Output channel m_*: one
// word per lag with both window sums, the mean overlap and chi4.
// Configuration: cfg_wr_en / cfg_index / cfg_wr_data, written while idle.
// An atom word is accepted, squared and compared in turn (ST_IDLE, ST_SQUARE,
// ST_TALLY) before the next is taken; the last atom of a window adds the
// window close (ST_CLOSE_SQ, ST_CLOSE_ADD). After the last window the output
// word follows the five lag-end products, computed in turn on the shared
// 32 x 32 multiplier; no atom word is taken meanwhile.
// Reset (synchronous, active low) restores the register defaults, clears the
// running counts and sums and drops m_valid.
// A stalled receiver blocks the next output word, and atom words with it;
// till then atoms are still taken while a word waits in the output register.
// Depends on osa_pkg, osa_ctrl and osa_datapath.
`timescale 1ns / 1ps
`default_nettype none

module overlap_susceptibility_accumulator #(
    parameter int MAX_ATOMS   = osa_pkg::DEF_MAX_ATOMS,
    parameter int MAX_WINDOWS = osa_pkg::DEF_MAX_WINDOWS
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic [osa_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [osa_pkg::CFG_W-1:0]           cfg_wr_data,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic signed [osa_pkg::COORD_W-1:0]  s_now_x,
    input  logic signed [osa_pkg::COORD_W-1:0]  s_now_y,
    input  logic signed [osa_pkg::COORD_W-1:0]  s_now_z,
    input  logic signed [osa_pkg::COORD_W-1:0]  s_start_x,
    input  logic signed [osa_pkg::COORD_W-1:0]  s_start_y,
    input  logic signed [osa_pkg::COORD_W-1:0]  s_start_z,
    input  logic                                s_last_atom,
    input  logic                                s_last_window,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [osa_pkg::SUM_W-1:0]           m_overlap_sum,
    output logic [osa_pkg::SQSUM_W-1:0]         m_overlap_square_sum,
    output logic [osa_pkg::MEAN_W-1:0]          m_mean_overlap,
    output logic signed [osa_pkg::CHI_W-1:0]    m_chi4_value
);

    osa_pkg::cmd_t    cmd;
    osa_pkg::status_t status;

    osa_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd),
        .status  (status)
    );

    osa_datapath #(
        .MAX_ATOMS   (MAX_ATOMS),
        .MAX_WINDOWS (MAX_WINDOWS)
    ) u_datapath (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cfg_wr_en          (cfg_wr_en),
        .cfg_index          (cfg_index),
        .cfg_wr_data        (cfg_wr_data),
        .now_x              (s_now_x),
        .now_y              (s_now_y),
        .now_z              (s_now_z),
        .start_x            (s_start_x),
        .start_y            (s_start_y),
        .start_z            (s_start_z),
        .last_atom          (s_last_atom),
        .last_window        (s_last_window),
        .cmd                (cmd),
        .status             (status),
        .overlap_sum        (m_overlap_sum),
        .overlap_square_sum (m_overlap_square_sum),
        .mean_overlap       (m_mean_overlap),
        .chi4_value         (m_chi4_value)
    );

endmodule

`default_nettype wire
